>>> src/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// shared constants and command/status types for the discrete log search
// ----------------------------------------------------------------------------
package dls_pkg;

   localparam int DefModWidth = 16;
   localparam int CfgIdxWidth = 1;
   localparam int ValWidth    = 16;

   localparam logic [CfgIdxWidth-1:0] RegGenerator = 1'b0;
   localparam logic [CfgIdxWidth-1:0] RegModulus   = 1'b1;

   localparam logic [ValWidth-1:0] GeneratorReset = 16'd2;
   localparam logic [ValWidth-1:0] ModulusReset   = 16'd23;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture target, start reducing generator
      logic red_step;  // one restoring step of generator mod m
      logic mul_start; // begin power * g mod m
      logic mul_step;  // one step of the shift-add modular multiply
      logic compare;   // check power against target, advance exponent
   } dls_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mod_small; // modulus below two
      logic red_done;
      logic mul_done;
      logic last_exp;  // exponent being compared is modulus-1
   } dls_status_type;

endpackage

>>> src/dls_datapath.sv
// ----------------------------------------------------------------------------
// dls_datapath
// generator reduction, bit-serial modular multiply, exponent scan and match
// ----------------------------------------------------------------------------
module dls_datapath #(
   parameter int MOD_WIDTH = dls_pkg::DefModWidth
) (
   input  logic                          clock,
   input  logic [dls_pkg::ValWidth-1:0]  generator,
   input  logic [dls_pkg::ValWidth-1:0]  modulus,
   input  logic [dls_pkg::ValWidth-1:0]  target,
   input  dls_pkg::dls_cmd_type          cmd,
   output dls_pkg::dls_status_type       status,
   output logic                          found,
   output logic [dls_pkg::ValWidth-1:0]  best_exp
);
   import dls_pkg::*;

   localparam int W  = MOD_WIDTH;
   localparam int GW = (ValWidth > W) ? ValWidth : W;
   localparam int CW = $clog2(GW + 1);

   logic [W-1:0]    m;
   logic [GW-1:0]   m_ext;
   logic [W:0]      m_wide;

   logic [GW-1:0]   red_ff, red_in;      // generator remainder
   logic [GW-1:0]   gsh_ff, gsh_in;      // generator bits shifted out msb first
   logic [CW-1:0]   rcnt_ff, rcnt_in;
   logic [W-1:0]    g_ff;
   logic [W-1:0]    pow_ff, pow_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic [W-1:0]    mb_ff, mb_in;        // multiplier bits, msb first
   logic [CW-1:0]   mcnt_ff, mcnt_in;
   logic [W-1:0]    exp_ff, exp_in;
   logic [ValWidth-1:0] tgt_ff;
   logic            found_ff, found_in;
   logic [ValWidth-1:0] best_ff, best_in;

   logic [GW:0]     r2;
   logic [W:0]      a2, a3;
   logic [W-1:0]    a_dbl, a_add;

   // zero-extended or truncated to the working width
   assign m      = W'(modulus);
   assign m_ext  = GW'(m);
   assign m_wide = {1'b0, m};

   always_comb begin
      // restoring remainder step
      r2 = {red_ff, gsh_ff[GW-1]};
      if (r2 >= {1'b0, m_ext}) r2 = r2 - {1'b0, m_ext};
      // acc = 2*acc mod m, then + g if bit set
      a2 = {acc_ff, 1'b0};
      if (a2 >= m_wide) a2 = a2 - m_wide;
      a_dbl = a2[W-1:0];
      a3 = {1'b0, a_dbl} + {1'b0, g_ff};
      if (a3 >= m_wide) a3 = a3 - m_wide;
      a_add = mb_ff[W-1] ? a3[W-1:0] : a_dbl;
   end

   always_comb begin
      red_in   = red_ff;
      gsh_in   = gsh_ff;
      rcnt_in  = rcnt_ff;
      pow_in   = pow_ff;
      acc_in   = acc_ff;
      mb_in    = mb_ff;
      mcnt_in  = mcnt_ff;
      exp_in   = exp_ff;
      found_in = found_ff;
      best_in  = best_ff;
      if (cmd.load) begin
         red_in   = '0;
         gsh_in   = GW'(generator);
         rcnt_in  = '0;
         pow_in   = W'(1);
         exp_in   = W'(1);
         found_in = 1'b0;
         best_in  = '0;
      end
      if (cmd.red_step) begin
         red_in  = r2[GW-1:0];
         gsh_in  = {gsh_ff[GW-2:0], 1'b0};
         rcnt_in = rcnt_ff + CW'(1);
      end
      if (cmd.mul_start) begin
         acc_in  = '0;
         mb_in   = pow_ff;
         mcnt_in = '0;
      end
      if (cmd.mul_step) begin
         acc_in  = a_add;
         mb_in   = {mb_ff[W-2:0], 1'b0};
         mcnt_in = mcnt_ff + CW'(1);
      end
      if (cmd.compare) begin
         pow_in = acc_ff;
         exp_in = exp_ff + W'(1);
         if (GW'(acc_ff) == GW'(tgt_ff)) begin
            found_in = 1'b1;
            best_in  = ValWidth'(exp_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      gsh_ff   <= gsh_in;
      rcnt_ff  <= rcnt_in;
      pow_ff   <= pow_in;
      acc_ff   <= acc_in;
      mb_ff    <= mb_in;
      mcnt_ff  <= mcnt_in;
      exp_ff   <= exp_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      if (cmd.load) tgt_ff <= target;
      if (cmd.red_step && rcnt_ff == CW'(GW - 1)) g_ff <= r2[W-1:0];
   end

   assign status.mod_small = (m < W'(2));
   assign status.red_done  = (rcnt_ff == CW'(GW));
   assign status.mul_done  = (mcnt_ff == CW'(W));
   assign status.last_exp  = (exp_ff == m - W'(1));
   assign found            = found_ff;
   assign best_exp         = best_ff;

endmodule

>>> src/dls_ctrl.sv
// ----------------------------------------------------------------------------
// dls_ctrl
// sequencer for the search: reduce, then multiply and compare per exponent
// ----------------------------------------------------------------------------
module dls_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dls_pkg::dls_cmd_type     cmd,
   input  dls_pkg::dls_status_type  status
);
   import dls_pkg::*;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StReduce = 3'd1;
   localparam logic [2:0] StMulGo  = 3'd2;
   localparam logic [2:0] StMul    = 3'd3;
   localparam logic [2:0] StCmp    = 3'd4;
   localparam logic [2:0] StResp   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != StIdle);
   assign rsp_valid = (state_ff == StResp);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StReduce;
            end
         end
         StReduce: begin
            if (status.mod_small) state_in = StResp;
            else if (status.red_done) state_in = StMulGo;
            else cmd.red_step = 1'b1;
         end
         StMulGo: begin
            cmd.mul_start = 1'b1;
            state_in      = StMul;
         end
         StMul: begin
            if (status.mul_done) state_in = StCmp;
            else cmd.mul_step = 1'b1;
         end
         StCmp: begin
            cmd.compare = 1'b1;
            state_in    = status.last_exp ? StResp : StMulGo;
         end
         StResp: begin
            if (!rsp_stall) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= StIdle;
      else       state_ff <= state_in;
   end

   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid && !req_stall)
      else $error("response not retired");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while response pending");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == StReduce)
      else $error("search not started");

endmodule

>>> src/discrete_log_search.sv
// ----------------------------------------------------------------------------
// discrete_log_search
// brute-force discrete logarithm over exponents 1 .. modulus-1
// ----------------------------------------------------------------------------
// One public value is taken per beat on the req_ channel; one result beat
// (found, private_exponent) leaves on the rsp_ channel. The block works on
// a single item: req_stall stays high from acceptance until the result beat
// has been taken, and the next value can be taken the cycle after that.
// The result is the largest exponent e with generator^e mod modulus equal
// to the value, or found 0 / exponent 0.
// The generator is reduced by G restoring steps, one per cycle, G being the
// larger of 16 and MOD_WIDTH, plus a state to see it finish; then each
// exponent costs one bit-serial modular multiply of MOD_WIDTH steps plus
// a start, a finish and a compare state. A modulus below two skips the
// search: the reduce state goes straight to the response. The result is
// held while rsp_stall is high. The csr_ channel is always ready;
// write only while idle. Reset (synchronous) returns to idle and sets
// generator 2, modulus 23.
// ----------------------------------------------------------------------------
module discrete_log_search #(
   parameter int MOD_WIDTH = dls_pkg::DefModWidth
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dls_pkg::ValWidth-1:0]        req_public_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [dls_pkg::ValWidth-1:0]        rsp_private_exponent,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dls_pkg::CfgIdxWidth-1:0]     csr_index,
   input  logic [dls_pkg::ValWidth-1:0]        csr_data
);
   import dls_pkg::*;

   logic [ValWidth-1:0] generator_ff, modulus_ff;
   dls_cmd_type         cmd;
   dls_status_type      status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         generator_ff <= GeneratorReset;
         modulus_ff   <= ModulusReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            RegGenerator: generator_ff <= csr_data;
            RegModulus:   modulus_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   dls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dls_datapath #(.MOD_WIDTH(MOD_WIDTH)) u_dp (
      .clock     (clock),
      .generator (generator_ff),
      .modulus   (modulus_ff),
      .target    (req_public_value),
      .cmd       (cmd),
      .status    (status),
      .found     (rsp_found),
      .best_exp  (rsp_private_exponent)
   );

   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_private_exponent == '0)
      else $error("exponent set without a match");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_private_exponent) && $stable(rsp_found))
      else $error("result changed while stalled");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_private_exponent != '0)
      else $error("matched exponent out of range");

endmodule
